/* rtl/sdqf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdqf_pkg: shared types and constants
// Widths, stream header bytes, slot codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdqf_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int SUM_W      = 27;
	localparam int CNT_W      = 3;
	localparam int N_W        = 4;
	localparam int GAIN_W     = 10;
	localparam int SCALE_W    = 23;
	localparam int FRAC_W     = 23;
	localparam int PROD1_W    = SUM_W + GAIN_W;
	localparam int NUM_W      = 26;
	localparam int PROD2_W    = NUM_W + SCALE_W;
	localparam int DIGIT_W    = 4;
	localparam int DIV_STEPS  = 7;
	localparam int DIV_W      = DIGIT_W * DIV_STEPS;
	localparam int STEP_W     = 3;
	localparam int REM_W      = 3;
	localparam int SLOT_W     = 4;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;

	localparam logic [CNT_W-1:0]  DECIMATION_RST = 3'd1;
	localparam logic              WIDE_RST       = 1'b1;
	localparam logic [GAIN_W-1:0] GAIN_RST       = 10'd100;

	localparam logic [BYTE_W-1:0] SYNC0_BYTE = 8'hDA;
	localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'h7A;
	localparam logic [BYTE_W-1:0] FMT_WIDE   = 8'h80;
	localparam logic [BYTE_W-1:0] FMT_NARROW = 8'h00;
	localparam logic [BYTE_W-1:0] FMT_MARK   = 8'h40;

	localparam logic [SCALE_W-1:0] SCALE_WIDE   = 23'd8388607;
	localparam logic [SCALE_W-1:0] SCALE_NARROW = 23'd32767;

	localparam logic [CNT_W-1:0] WIDE_BYTES   = 3'd3;
	localparam logic [CNT_W-1:0] NARROW_BYTES = 3'd2;

	localparam logic [SLOT_W-1:0] SLOT_SYNC0      = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_SYNC1      = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_SEQ        = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_FMT        = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_SAMPLE     = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_END_NARROW = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_END_WIDE   = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              take;
		logic              mul1;
		logic              mul2;
		logic              div_step;
		logic              finish;
		logic              emit;
		logic              last;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic group_done;
		logic hdr;
		logic wide;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/sdqf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdqf_div: radix-16 restoring divider lane
// Divides the scaled product by the group size, four quotient bits per step.
// ----------------------------------------------------------------------------
module sdqf_div (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic [sdqf_pkg::NUM_W-1:0]    dividend,
	input  logic [sdqf_pkg::N_W-1:0]      divisor,
	output logic [sdqf_pkg::SCALE_W-1:0]  quotient
);
	import sdqf_pkg::*;

	logic [DIV_W-1:0] acc_q;
	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] acc_d;
	logic [REM_W-1:0] rem_d;

	always_comb begin
		logic [REM_W:0]   part;
		logic [DIGIT_W-1:0] qd;
		part  = '0;
		qd    = '0;
		rem_d = rem_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			part = {rem_d, acc_q[DIV_W-1-i]};
			if (part >= divisor) begin
				part = part - divisor;
				qd[DIGIT_W-1-i] = 1'b1;
			end
			rem_d = part[REM_W-1:0];
		end
		acc_d = {acc_q[DIV_W-DIGIT_W-1:0], qd};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= {{(DIV_W-NUM_W){1'b0}}, dividend};
			rem_q <= '0;
		end else if (step) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
		end
	end

	assign quotient = acc_q[SCALE_W-1:0];

endmodule
`default_nettype wire

/* rtl/sdqf_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdqf_dpath: accumulate, quantize and framing datapath
// Holds the registers, the running sums, the frame counters, the two
// multiply stages, two divider lanes, the byte selector and output register.
// ----------------------------------------------------------------------------
module sdqf_dpath #(
	parameter int PAIRS_PER_FRAME = 64,
	parameter int MAX_DECIMATION  = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sdqf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdqf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [sdqf_pkg::SAMPLE_W-1:0] in_left,
	input  logic signed [sdqf_pkg::SAMPLE_W-1:0] in_right,
	input  sdqf_pkg::cmd_t                      cmd,
	output sdqf_pkg::sts_t                      sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sdqf_pkg::BYTE_W-1:0]         out_byte,
	output logic                                out_last,
	output logic                                out_frame
);
	import sdqf_pkg::*;

	localparam int PIF_W = (PAIRS_PER_FRAME > 1) ? $clog2(PAIRS_PER_FRAME) : 1;
	localparam logic [PIF_W-1:0] PIF_LAST = PIF_W'(PAIRS_PER_FRAME - 1);
	localparam logic [CNT_W-1:0] DEC_CAP  =
		(MAX_DECIMATION > ((1 << CNT_W) - 1)) ? CNT_W'((1 << CNT_W) - 1)
		                                      : CNT_W'(MAX_DECIMATION);

	logic [CNT_W-1:0]  dec_q;
	logic              wide_q;
	logic [GAIN_W-1:0] gain_q;

	logic signed [SUM_W-1:0] lsum_q, rsum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PIF_W-1:0]        pair_q;
	logic [BYTE_W-1:0]       seq_q;

	logic signed [SUM_W-1:0] lsum_new, rsum_new;
	logic [CNT_W-1:0]        cnt_new;
	logic [CNT_W-1:0]        eff_dec;
	logic [N_W-1:0]          n_new;
	logic                    group_done;

	logic signed [SUM_W-1:0] lw_q, rw_q;
	logic [N_W-1:0]          n_q;
	logic                    wide_w_q;
	logic                    hdr_q;
	logic                    fdone_q;
	logic [BYTE_W-1:0]       seqw_q;
	logic [BYTE_W-1:0]       fmt_q;

	logic [SUM_W-1:0]        lmag, rmag;
	logic [PROD1_W-1:0]      lprod_q, rprod_q;
	logic                    lneg_q, rneg_q;
	logic                    lsat_q, rsat_q;
	logic [PROD1_W-1:0]      den;
	logic [SCALE_W-1:0]      scale;
	logic [PROD2_W-1:0]      lprod2, rprod2;
	logic [SCALE_W-1:0]      lquo, rquo;
	logic [SCALE_W-1:0]      lq, rq;
	logic [SAMPLE_W-1:0]     ls_q, rs_q;

	logic [CNT_W-1:0]        rel;
	logic [CNT_W-1:0]        nbytes;
	logic [CNT_W-1:0]        lane_idx;
	logic [SAMPLE_W-1:0]     lane_word;
	logic [BYTE_W-1:0]       sample_byte;
	logic [BYTE_W-1:0]       next_byte;

	logic                    out_valid_q;
	logic [BYTE_W-1:0]       byte_q;
	logic                    last_q;
	logic                    frame_q;

	assign eff_dec  = (dec_q == '0) ? CNT_W'(1) : ((dec_q > DEC_CAP) ? DEC_CAP : dec_q);
	assign lsum_new = lsum_q + SUM_W'(in_left);
	assign rsum_new = rsum_q + SUM_W'(in_right);
	assign cnt_new  = cnt_q + CNT_W'(1);
	assign group_done = (cnt_new >= eff_dec) || (cnt_new == '0);
	assign n_new    = (cnt_new == '0) ? N_W'(1 << CNT_W) : N_W'(cnt_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q  <= DECIMATION_RST;
			wide_q <= WIDE_RST;
			gain_q <= GAIN_RST;
			lsum_q <= '0;
			rsum_q <= '0;
			cnt_q  <= '0;
			pair_q <= '0;
			seq_q  <= '0;
		end else begin
			if (cmd.take) begin
				if (group_done) begin
					lsum_q <= '0;
					rsum_q <= '0;
					cnt_q  <= '0;
					pair_q <= (pair_q == PIF_LAST) ? '0 : pair_q + PIF_W'(1);
					if (pair_q == '0) begin
						seq_q <= seq_q + BYTE_W'(1);
					end
				end else begin
					lsum_q <= lsum_new;
					rsum_q <= rsum_new;
					cnt_q  <= cnt_new;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DECIMATION: begin
						dec_q  <= cfg_data[CNT_W-1:0];
						pair_q <= '0;
					end
					REG_WIDE_SAMPLES: begin
						wide_q <= cfg_data[0];
						pair_q <= '0;
					end
					REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// capture a completed group
	always_ff @(posedge clk) begin
		if (cmd.take && group_done) begin
			lw_q     <= lsum_new;
			rw_q     <= rsum_new;
			n_q      <= n_new;
			wide_w_q <= wide_q;
			hdr_q    <= (pair_q == '0);
			fdone_q  <= (pair_q == PIF_LAST);
			seqw_q   <= seq_q;
			fmt_q    <= (wide_q ? FMT_WIDE : FMT_NARROW) | FMT_MARK | BYTE_W'(eff_dec);
		end
	end

	assign lmag = lw_q[SUM_W-1] ? SUM_W'(-lw_q) : SUM_W'(lw_q);
	assign rmag = rw_q[SUM_W-1] ? SUM_W'(-rw_q) : SUM_W'(rw_q);

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			lprod_q <= PROD1_W'(lmag) * PROD1_W'(gain_q);
			rprod_q <= PROD1_W'(rmag) * PROD1_W'(gain_q);
			lneg_q  <= lw_q[SUM_W-1];
			rneg_q  <= rw_q[SUM_W-1];
		end
	end

	assign den    = PROD1_W'({n_q, {FRAC_W{1'b0}}});
	assign scale  = wide_w_q ? SCALE_WIDE : SCALE_NARROW;
	assign lprod2 = PROD2_W'(lprod_q[NUM_W-1:0]) * PROD2_W'(scale);
	assign rprod2 = PROD2_W'(rprod_q[NUM_W-1:0]) * PROD2_W'(scale);

	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			lsat_q <= (lprod_q >= den);
			rsat_q <= (rprod_q >= den);
		end
	end

	sdqf_div u_div_left (
		.clk      (clk),
		.load     (cmd.mul2),
		.step     (cmd.div_step),
		.dividend (lprod2[PROD2_W-1:FRAC_W]),
		.divisor  (n_q),
		.quotient (lquo)
	);

	sdqf_div u_div_right (
		.clk      (clk),
		.load     (cmd.mul2),
		.step     (cmd.div_step),
		.dividend (rprod2[PROD2_W-1:FRAC_W]),
		.divisor  (n_q),
		.quotient (rquo)
	);

	assign lq = lsat_q ? scale : lquo;
	assign rq = rsat_q ? scale : rquo;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ls_q <= lneg_q ? SAMPLE_W'(-SAMPLE_W'(lq)) : SAMPLE_W'(lq);
			rs_q <= rneg_q ? SAMPLE_W'(-SAMPLE_W'(rq)) : SAMPLE_W'(rq);
		end
	end

	assign rel    = CNT_W'(cmd.slot - SLOT_SAMPLE);
	assign nbytes = wide_w_q ? WIDE_BYTES : NARROW_BYTES;

	always_comb begin
		if (rel < nbytes) begin
			lane_word = ls_q;
			lane_idx  = rel;
		end else begin
			lane_word = rs_q;
			lane_idx  = rel - nbytes;
		end
		case (lane_idx)
			3'd0:    sample_byte = lane_word[BYTE_W-1:0];
			3'd1:    sample_byte = lane_word[2*BYTE_W-1:BYTE_W];
			default: sample_byte = lane_word[3*BYTE_W-1:2*BYTE_W];
		endcase
		unique case (cmd.slot)
			SLOT_SYNC0: next_byte = SYNC0_BYTE;
			SLOT_SYNC1: next_byte = SYNC1_BYTE;
			SLOT_SEQ:   next_byte = seqw_q;
			SLOT_FMT:   next_byte = fmt_q;
			default:    next_byte = sample_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q  <= next_byte;
			last_q  <= cmd.last;
			frame_q <= cmd.last & fdone_q;
		end
	end

	assign sts.group_done = group_done;
	assign sts.hdr        = hdr_q;
	assign sts.wide       = wide_w_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_frame = frame_q;

endmodule
`default_nettype wire

/* rtl/sdqf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdqf_ctrl: sequencing state machine
// Accepts pairs, steps the multiply and divide stages and walks the byte
// slots of the header and samples into the output register.
// ----------------------------------------------------------------------------
module sdqf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sdqf_pkg::sts_t sts,
	output sdqf_pkg::cmd_t cmd
);
	import sdqf_pkg::*;

	state_t             state_q, state_d;
	logic [STEP_W-1:0]  step_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  slot_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.slot = slot_q;
		slot_end = sts.wide ? SLOT_END_WIDE : SLOT_END_NARROW;
		cmd.last = (slot_q == slot_end);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.group_done) begin
						state_d = ST_MUL1;
					end
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (cmd.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			slot_q <= '0;
		end else begin
			if (cmd.mul2) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.finish) begin
				slot_q <= sts.hdr ? SLOT_SYNC0 : SLOT_SAMPLE;
			end else if (cmd.emit) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/stereo_decimate_quantize_framer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_decimate_quantize_framer: box-car decimator with PCM byte framer
// A pair that only accumulates is added to the running sums when taken.
// A pair that closes a group goes through 2 multiply, 7 radix-16 divide
// and 1 finalize step before its first byte, then one byte per cycle while
// the output is free: 4 header bytes when a frame opens, then 4 or 6 sample
// bytes. The next pair is taken once the last byte is in the output register.
// Reset clears sums, counters and frame sequence; decimation 1, wide, gain 100.
// ----------------------------------------------------------------------------
module stereo_decimate_quantize_framer #(
	parameter int PAIRS_PER_FRAME = 64,
	parameter int MAX_DECIMATION  = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [47:0]                         s_axis_tdata,  // left_sample, right_sample
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [sdqf_pkg::BYTE_W-1:0]         m_axis_tdata,  // out_byte
	output logic                                m_axis_tlast,  // item_done
	output logic [0:0]                          m_axis_tuser,  // frame_done
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sdqf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdqf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sdqf_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic frame_done;

	assign cfg_ready = 1'b1;

	sdqf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdqf_dpath #(
		.PAIRS_PER_FRAME (PAIRS_PER_FRAME),
		.MAX_DECIMATION  (MAX_DECIMATION)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_left   (s_axis_tdata[SAMPLE_W-1:0]),
		.in_right  (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_frame (frame_done)
	);

	assign m_axis_tuser = frame_done;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("byte loaded over an untaken byte");

	a_frame_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("frame end not on the last byte of a pair");

	a_busy_after_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && sts.group_done |=> !s_axis_tready)
		else $error("input taken while a group is in progress");

endmodule
`default_nettype wire
